@@ src/cbps_pkg.sv @@
// shared types and constants of the cubic b-spline path sampler
package cbps_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int SEG_W      = 6;
   localparam int LANES      = 3;
   localparam int TAPS       = 4;
   localparam int TAP_W      = 2;
   localparam int MPROD_W    = DATA_W + SEG_W;
   localparam int DVD_W      = MPROD_W + FRAC_BITS;
   localparam int DIV_STEPS  = DVD_W;
   localparam int U_W        = FRAC_BITS + 1;
   localparam int WGT_W      = FRAC_BITS + 4;
   localparam int PROD_W     = DATA_W + WGT_W;
   localparam int ACC_W      = PROD_W + 3;
   localparam int NORM_BITS  = 4;
   localparam int NQ_W       = 40;
   localparam int NORM_STEPS = NQ_W / NORM_BITS;
   localparam int CNT_W      = 6;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_TIME    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_COUNT = 1'd1;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam logic [DATA_W-1:0] TOTAL_TIME_RST = 32'h0001_0000;
   localparam logic [SEG_W-1:0]  SEG_COUNT_RST  = 6'd1;
   localparam logic [U_W-1:0]    ONE_U          = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [3:0]        SIX            = 4'd6;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_WRITE,
      OP_LOAD,
      OP_DIV_STEP,
      OP_SEG,
      OP_SQ,
      OP_CUBE,
      OP_WGT,
      OP_RD,
      OP_MUL,
      OP_ACC,
      OP_NORM_INIT,
      OP_NORM_STEP,
      OP_POSE,
      OP_VEL_LO,
      OP_VEL_HI,
      OP_OUT,
      OP_RATE_INIT,
      OP_RATE_SET
   } dp_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIV,
      ST_SEG,
      ST_SQ,
      ST_CUBE,
      ST_WGT,
      ST_RD,
      ST_MUL,
      ST_ACC,
      ST_NORM_INIT,
      ST_NORM,
      ST_POSE,
      ST_VEL_LO,
      ST_VEL_HI,
      ST_OUT,
      ST_RATE_INIT,
      ST_RATE,
      ST_RATE_SET
   } state_type;

   typedef struct packed {
      dp_op_type        op;
      logic [TAP_W-1:0] tap;
   } dp_cmd_type;

   typedef struct packed {
      logic first;
      logic out_free;
   } dp_status_type;

endpackage

@@ src/cbps_ctrl.sv @@
// sequencing state machine of the path sampler
module cbps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_func,
   input  cbps_pkg::dp_status_type status,
   output cbps_pkg::dp_cmd_type   cmd,
   output logic                   req_stall
);

   cbps_pkg::state_type state_ff, state_in;
   logic [cbps_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [cbps_pkg::TAP_W-1:0] tap_ff, tap_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbps_pkg::ST_IDLE;
         cnt_ff   <= '0;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         tap_ff   <= tap_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cbps_pkg::ST_IDLE: begin
            if (req_valid && req_func == cbps_pkg::FUNC_SAMPLE) state_in = cbps_pkg::ST_DIV;
         end
         cbps_pkg::ST_DIV: begin
            if (cnt_ff == cbps_pkg::CNT_W'(cbps_pkg::DIV_STEPS - 1))
               state_in = cbps_pkg::ST_SEG;
         end
         cbps_pkg::ST_SEG:  state_in = cbps_pkg::ST_SQ;
         cbps_pkg::ST_SQ:   state_in = cbps_pkg::ST_CUBE;
         cbps_pkg::ST_CUBE: state_in = cbps_pkg::ST_WGT;
         cbps_pkg::ST_WGT:  state_in = cbps_pkg::ST_RD;
         cbps_pkg::ST_RD:   state_in = cbps_pkg::ST_MUL;
         cbps_pkg::ST_MUL:  state_in = cbps_pkg::ST_ACC;
         cbps_pkg::ST_ACC: begin
            if (tap_ff == cbps_pkg::TAP_W'(cbps_pkg::TAPS - 1))
               state_in = cbps_pkg::ST_NORM_INIT;
            else
               state_in = cbps_pkg::ST_RD;
         end
         cbps_pkg::ST_NORM_INIT: state_in = cbps_pkg::ST_NORM;
         cbps_pkg::ST_NORM: begin
            if (cnt_ff == cbps_pkg::CNT_W'(cbps_pkg::NORM_STEPS - 1))
               state_in = cbps_pkg::ST_POSE;
         end
         cbps_pkg::ST_POSE:   state_in = cbps_pkg::ST_VEL_LO;
         cbps_pkg::ST_VEL_LO: state_in = cbps_pkg::ST_VEL_HI;
         cbps_pkg::ST_VEL_HI: state_in = cbps_pkg::ST_OUT;
         cbps_pkg::ST_OUT: begin
            if (status.out_free)
               state_in = status.first ? cbps_pkg::ST_RATE_INIT : cbps_pkg::ST_IDLE;
         end
         cbps_pkg::ST_RATE_INIT: state_in = cbps_pkg::ST_RATE;
         cbps_pkg::ST_RATE: begin
            if (cnt_ff == cbps_pkg::CNT_W'(cbps_pkg::DIV_STEPS - 1))
               state_in = cbps_pkg::ST_RATE_SET;
         end
         cbps_pkg::ST_RATE_SET: state_in = cbps_pkg::ST_IDLE;
         default: state_in = cbps_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = (state_in != state_ff) ? '0 : cnt_ff + 1'b1;
      tap_in = tap_ff;
      if (state_ff == cbps_pkg::ST_WGT) tap_in = '0;
      else if (state_ff == cbps_pkg::ST_ACC) tap_in = tap_ff + 1'b1;
   end

   // outputs
   always_comb begin
      cmd.op    = cbps_pkg::OP_NONE;
      cmd.tap   = tap_ff;
      req_stall = (state_ff != cbps_pkg::ST_IDLE);
      unique case (state_ff)
         cbps_pkg::ST_IDLE: begin
            if (req_valid)
               cmd.op = (req_func == cbps_pkg::FUNC_SAMPLE) ? cbps_pkg::OP_LOAD
                                                            : cbps_pkg::OP_WRITE;
         end
         cbps_pkg::ST_DIV,
         cbps_pkg::ST_RATE:      cmd.op = cbps_pkg::OP_DIV_STEP;
         cbps_pkg::ST_SEG:       cmd.op = cbps_pkg::OP_SEG;
         cbps_pkg::ST_SQ:        cmd.op = cbps_pkg::OP_SQ;
         cbps_pkg::ST_CUBE:      cmd.op = cbps_pkg::OP_CUBE;
         cbps_pkg::ST_WGT:       cmd.op = cbps_pkg::OP_WGT;
         cbps_pkg::ST_RD:        cmd.op = cbps_pkg::OP_RD;
         cbps_pkg::ST_MUL:       cmd.op = cbps_pkg::OP_MUL;
         cbps_pkg::ST_ACC:       cmd.op = cbps_pkg::OP_ACC;
         cbps_pkg::ST_NORM_INIT: cmd.op = cbps_pkg::OP_NORM_INIT;
         cbps_pkg::ST_NORM:      cmd.op = cbps_pkg::OP_NORM_STEP;
         cbps_pkg::ST_POSE:      cmd.op = cbps_pkg::OP_POSE;
         cbps_pkg::ST_VEL_LO:    cmd.op = cbps_pkg::OP_VEL_LO;
         cbps_pkg::ST_VEL_HI:    cmd.op = cbps_pkg::OP_VEL_HI;
         cbps_pkg::ST_OUT: begin
            if (status.out_free) cmd.op = cbps_pkg::OP_OUT;
         end
         cbps_pkg::ST_RATE_INIT: cmd.op = cbps_pkg::OP_RATE_INIT;
         cbps_pkg::ST_RATE_SET:  cmd.op = cbps_pkg::OP_RATE_SET;
         default:                cmd.op = cbps_pkg::OP_NONE;
      endcase
   end

endmodule

@@ src/cbps_dp.sv @@
// datapath of the path sampler: point table, divider, basis, blend and velocity
module cbps_dp #(
   parameter int MAX_POINTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cbps_pkg::dp_cmd_type                cmd,
   output cbps_pkg::dp_status_type             status,
   input  logic                                csr_valid,
   input  logic [cbps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [31:0]                         csr_data,
   input  logic [5:0]                          req_point_index,
   input  logic signed [31:0]                  req_point_x,
   input  logic signed [31:0]                  req_point_y,
   input  logic signed [31:0]                  req_point_heading,
   input  logic [31:0]                         req_time_now,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [31:0]                  rsp_target_x,
   output logic signed [31:0]                  rsp_target_y,
   output logic signed [31:0]                  rsp_target_heading,
   output logic signed [31:0]                  rsp_speed_x,
   output logic signed [31:0]                  rsp_speed_y,
   output logic signed [31:0]                  rsp_turn_rate,
   output logic                                rsp_done_res
);

   localparam int AW     = $clog2(MAX_POINTS);
   localparam int F      = cbps_pkg::FRAC_BITS;
   localparam int DW     = cbps_pkg::DATA_W;
   localparam int L      = cbps_pkg::LANES;
   localparam int SW     = cbps_pkg::SEG_W;
   localparam int UW     = cbps_pkg::U_W;
   localparam int WW     = cbps_pkg::WGT_W;
   localparam int QW     = cbps_pkg::NQ_W;
   localparam int VLO_W  = 16 + DW;
   localparam int VHI_W  = 17 + DW;
   localparam int VQ_W   = VHI_W + 1;

   // config
   logic [DW-1:0] total_time_ff;
   logic [SW-1:0] seg_count_ff;

   // point table
   logic [L*DW-1:0] mem [MAX_POINTS];
   logic [L*DW-1:0] rd_word_ff;
   logic signed [DW-1:0] rd_lane [L];

   logic [DW-1:0] t_ff;
   logic [SW-1:0] n_ff;
   logic [cbps_pkg::DVD_W-1:0] div_q_ff;
   logic [DW-1:0] div_r_ff, div_d_ff;
   logic [SW-1:0] k_ff;
   logic [UW-1:0] u_ff, v_ff, u2_ff, v2_ff, u3_ff, v3_ff;
   logic signed [WW-1:0] w_ff [cbps_pkg::TAPS];
   logic signed [cbps_pkg::PROD_W-1:0] prod_ff [L];
   logic signed [cbps_pkg::ACC_W-1:0] acc_ff [L];
   logic [L-1:0] neg_ff;
   logic [QW-1:0] nq_ff [L];
   logic [2:0] nr_ff [L];
   logic signed [DW-1:0] pose_ff [L];
   logic signed [DW-1:0] prev_ff [L];
   logic [VLO_W-1:0] vlo_ff [L];
   logic [VHI_W-1:0] vhi_ff [L];
   logic [DW-1:0] rate_ff;
   logic first_ff;
   logic rsp_valid_ff;
   logic signed [DW-1:0] rsp_pose_ff [L];
   logic signed [DW-1:0] rsp_vel_ff [L];
   logic rsp_done_ff;

   // combinational
   logic [SW-1:0] n_sel;
   logic [DW-1:0] p_sel;
   logic [cbps_pkg::MPROD_W-1:0] m_prod;
   logic [DW:0] rem_sh, rem_nx;
   logic rem_ge;
   logic [cbps_pkg::MPROD_W-1:0] k_raw;
   logic [2*UW-1:0] uu, vv, uuu, vvv;
   logic signed [WW:0] u3s, u2s, us, ones, w1_c, w2_c;
   logic [AW-1:0] raddr, waddr;
   logic idx_ok;
   logic [QW-1:0] nq_nx [L];
   logic [2:0] nr_nx [L];
   logic [3:0] trial;
   logic signed [DW:0] diff [L];
   logic [L-1:0] dneg;
   logic [DW:0] dmag [L];
   logic [VQ_W-1:0] vq [L];
   logic signed [DW-1:0] pose_c [L], vel_c [L];

   assign rd_lane[0] = rd_word_ff[3*DW-1:2*DW];
   assign rd_lane[1] = rd_word_ff[2*DW-1:DW];
   assign rd_lane[2] = rd_word_ff[DW-1:0];

   always_comb begin
      n_sel = (seg_count_ff == '0) ? SW'(1) : seg_count_ff;
      if (32'(n_sel) > 32'(MAX_POINTS - 3)) n_sel = SW'(MAX_POINTS - 3);
      p_sel  = (total_time_ff == '0) ? DW'(1) : total_time_ff;
      m_prod = cbps_pkg::MPROD_W'(req_time_now) * cbps_pkg::MPROD_W'(n_sel);
      idx_ok = 32'(req_point_index) < 32'(MAX_POINTS);
      waddr  = AW'(req_point_index);
      raddr  = AW'(k_ff) + AW'(cmd.tap);
   end

   // restoring divider step
   always_comb begin
      rem_sh = {div_r_ff, div_q_ff[cbps_pkg::DVD_W-1]};
      rem_ge = rem_sh >= {1'b0, div_d_ff};
      rem_nx = rem_ge ? rem_sh - {1'b0, div_d_ff} : rem_sh;
      k_raw  = div_q_ff[cbps_pkg::DVD_W-1:F];
   end

   // basis products and weights
   always_comb begin
      uu   = (2*UW)'(u_ff) * (2*UW)'(u_ff);
      vv   = (2*UW)'(v_ff) * (2*UW)'(v_ff);
      uuu  = (2*UW)'(u2_ff) * (2*UW)'(u_ff);
      vvv  = (2*UW)'(v2_ff) * (2*UW)'(v_ff);
      u3s  = $signed((WW+1)'(u3_ff));
      u2s  = $signed((WW+1)'(u2_ff));
      us   = $signed((WW+1)'(u_ff));
      ones = $signed((WW+1)'(cbps_pkg::ONE_U));
      w1_c = (u3s <<< 1) + u3s - (u2s <<< 2) - (u2s <<< 1) + (ones <<< 2);
      w2_c = (u2s <<< 1) + u2s + (us <<< 1) + us + ones - (u3s <<< 1) - u3s;
   end

   // divide by six, four digits per step
   always_comb begin
      trial = '0;
      for (int l = 0; l < L; l++) begin
         nq_nx[l] = nq_ff[l];
         nr_nx[l] = nr_ff[l];
         for (int j = 0; j < cbps_pkg::NORM_BITS; j++) begin
            trial    = {nr_nx[l], nq_nx[l][QW-1]};
            nq_nx[l] = {nq_nx[l][QW-2:0], 1'b0};
            if (trial >= cbps_pkg::SIX) begin
               nr_nx[l]    = 3'(trial - cbps_pkg::SIX);
               nq_nx[l][0] = 1'b1;
            end else begin
               nr_nx[l] = trial[2:0];
            end
         end
      end
   end

   // pose saturation and velocity
   always_comb begin
      for (int l = 0; l < L; l++) begin
         if (neg_ff[l])
            pose_c[l] = (nq_ff[l] > QW'(33'h1_0000_0000 >> 1)) ? $signed(32'h8000_0000)
                                                              : $signed(DW'(-nq_ff[l]));
         else
            pose_c[l] = (nq_ff[l] > QW'(32'h7FFF_FFFF)) ? $signed(32'h7FFF_FFFF)
                                                       : $signed(nq_ff[l][DW-1:0]);
         diff[l] = (DW+1)'(pose_ff[l]) - (DW+1)'(prev_ff[l]);
         dneg[l] = diff[l][DW];
         dmag[l] = dneg[l] ? (DW+1)'(-diff[l]) : (DW+1)'(diff[l]);
         vq[l]   = VQ_W'(vhi_ff[l]) + VQ_W'(vlo_ff[l][VLO_W-1:16]);
         if (first_ff)
            vel_c[l] = '0;
         else if (dneg[l])
            vel_c[l] = (vq[l] >= VQ_W'(32'h8000_0000)) ? $signed(32'h8000_0000)
                                                       : $signed(DW'(-vq[l]));
         else
            vel_c[l] = (vq[l] > VQ_W'(32'h7FFF_FFFF)) ? $signed(32'h7FFF_FFFF)
                                                     : $signed(vq[l][DW-1:0]);
      end
   end

   // point table
   always_ff @(posedge clock) begin
      if (cmd.op == cbps_pkg::OP_WRITE && idx_ok)
         mem[waddr] <= {req_point_x, req_point_y, req_point_heading};
      if (cmd.op == cbps_pkg::OP_RD)
         rd_word_ff <= mem[raddr];
   end

   // control and state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         total_time_ff <= cbps_pkg::TOTAL_TIME_RST;
         seg_count_ff  <= cbps_pkg::SEG_COUNT_RST;
         first_ff      <= 1'b1;
         rate_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int l = 0; l < L; l++) prev_ff[l] <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               cbps_pkg::CSR_TOTAL_TIME:    total_time_ff <= csr_data;
               cbps_pkg::CSR_SEGMENT_COUNT: seg_count_ff  <= csr_data[SW-1:0];
               default: ;
            endcase
         end
         if (cmd.op == cbps_pkg::OP_OUT) begin
            rsp_valid_ff <= 1'b1;
            first_ff     <= t_ff > total_time_ff;
            for (int l = 0; l < L; l++) prev_ff[l] <= pose_ff[l];
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.op == cbps_pkg::OP_RATE_SET)
            rate_ff <= (|div_q_ff[cbps_pkg::DVD_W-1:DW]) ? '1 : div_q_ff[DW-1:0];
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      case (cmd.op)
         cbps_pkg::OP_LOAD: begin
            t_ff     <= req_time_now;
            n_ff     <= n_sel;
            div_q_ff <= {m_prod, {F{1'b0}}};
            div_r_ff <= '0;
            div_d_ff <= p_sel;
         end
         cbps_pkg::OP_RATE_INIT: begin
            div_q_ff <= cbps_pkg::DVD_W'(1) << (2*F);
            div_r_ff <= '0;
            div_d_ff <= t_ff;
         end
         cbps_pkg::OP_DIV_STEP: begin
            div_q_ff <= {div_q_ff[cbps_pkg::DVD_W-2:0], rem_ge};
            div_r_ff <= rem_nx[DW-1:0];
         end
         cbps_pkg::OP_SEG: begin
            if (k_raw >= cbps_pkg::MPROD_W'(n_ff)) begin
               k_ff <= n_ff - 1'b1;
               u_ff <= cbps_pkg::ONE_U;
               v_ff <= '0;
            end else begin
               k_ff <= k_raw[SW-1:0];
               u_ff <= {1'b0, div_q_ff[F-1:0]};
               v_ff <= cbps_pkg::ONE_U - {1'b0, div_q_ff[F-1:0]};
            end
         end
         cbps_pkg::OP_SQ: begin
            u2_ff <= uu[F+UW-1:F];
            v2_ff <= vv[F+UW-1:F];
         end
         cbps_pkg::OP_CUBE: begin
            u3_ff <= uuu[F+UW-1:F];
            v3_ff <= vvv[F+UW-1:F];
         end
         cbps_pkg::OP_WGT: begin
            w_ff[0] <= $signed(WW'(v3_ff));
            w_ff[1] <= WW'(w1_c);
            w_ff[2] <= WW'(w2_c);
            w_ff[3] <= $signed(WW'(u3_ff));
            for (int l = 0; l < L; l++) acc_ff[l] <= '0;
         end
         cbps_pkg::OP_MUL: begin
            for (int l = 0; l < L; l++) prod_ff[l] <= rd_lane[l] * w_ff[cmd.tap];
         end
         cbps_pkg::OP_ACC: begin
            for (int l = 0; l < L; l++)
               acc_ff[l] <= acc_ff[l] + cbps_pkg::ACC_W'(prod_ff[l]);
         end
         cbps_pkg::OP_NORM_INIT: begin
            for (int l = 0; l < L; l++) begin
               neg_ff[l] <= acc_ff[l][cbps_pkg::ACC_W-1];
               nq_ff[l]  <= acc_ff[l][cbps_pkg::ACC_W-1]
                            ? QW'((-acc_ff[l]) >>> F) : QW'(acc_ff[l] >>> F);
               nr_ff[l]  <= '0;
            end
         end
         cbps_pkg::OP_NORM_STEP: begin
            for (int l = 0; l < L; l++) begin
               nq_ff[l] <= nq_nx[l];
               nr_ff[l] <= nr_nx[l];
            end
         end
         cbps_pkg::OP_POSE: begin
            for (int l = 0; l < L; l++) pose_ff[l] <= pose_c[l];
         end
         cbps_pkg::OP_VEL_LO: begin
            for (int l = 0; l < L; l++)
               vlo_ff[l] <= VLO_W'(dmag[l][15:0]) * VLO_W'(rate_ff);
         end
         cbps_pkg::OP_VEL_HI: begin
            for (int l = 0; l < L; l++)
               vhi_ff[l] <= VHI_W'(dmag[l][DW:16]) * VHI_W'(rate_ff);
         end
         cbps_pkg::OP_OUT: begin
            for (int l = 0; l < L; l++) begin
               rsp_pose_ff[l] <= pose_ff[l];
               rsp_vel_ff[l]  <= vel_c[l];
            end
            rsp_done_ff <= t_ff > total_time_ff;
         end
         default: ;
      endcase
   end

   assign status.first    = first_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_target_x       = rsp_pose_ff[0];
   assign rsp_target_y       = rsp_pose_ff[1];
   assign rsp_target_heading = rsp_pose_ff[2];
   assign rsp_speed_x        = rsp_vel_ff[0];
   assign rsp_speed_y        = rsp_vel_ff[1];
   assign rsp_turn_rate      = rsp_vel_ff[2];
   assign rsp_done_res       = rsp_done_ff;

endmodule

@@ src/cubic_bspline_path_sampler.sv @@
// top level of the cubic b-spline path sampler
//
// req channel (valid/stall): func 0 loads one control point (x, y, heading)
// into the table in the accept cycle; func 1 asks for a path sample at
// time_now. A write request never stalls the block.
// rsp channel (valid/stall): one response per sample, none per write.
// csr channel (valid/ready, ready always high): index 0 total_time,
// index 1 segment_count; they are to be written only while the block is
// idle, which the block itself does not enforce. A sample runs the
// one-bit-per-cycle divider for segment and local parameter, then the
// basis, the four table reads and multiply-accumulates, the divide by six,
// saturation and velocity. After its response is placed, the first sample
// of a run reuses the divider for the reciprocal of the sample time.
// A response waits in its output register while rsp_stall is high; the
// block stalls new samples only while one is in work or cannot be placed.
// Reset clears the response, the previous pose and the rate, re-arms the
// first-sample flag and restores total_time and segment_count.
module cubic_bspline_path_sampler #(
   parameter int MAX_POINTS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_func,
   input  logic [5:0]                         req_point_index,
   input  logic signed [31:0]                 req_point_x,
   input  logic signed [31:0]                 req_point_y,
   input  logic signed [31:0]                 req_point_heading,
   input  logic [31:0]                        req_time_now,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [31:0]                 rsp_target_x,
   output logic signed [31:0]                 rsp_target_y,
   output logic signed [31:0]                 rsp_target_heading,
   output logic signed [31:0]                 rsp_speed_x,
   output logic signed [31:0]                 rsp_speed_y,
   output logic signed [31:0]                 rsp_turn_rate,
   output logic                               rsp_done_res,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cbps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_data
);

   cbps_pkg::dp_cmd_type    cmd;
   cbps_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   cbps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   cbps_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_valid          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_point_index    (req_point_index),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .req_point_heading  (req_point_heading),
      .req_time_now       (req_time_now),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_target_x       (rsp_target_x),
      .rsp_target_y       (rsp_target_y),
      .rsp_target_heading (rsp_target_heading),
      .rsp_speed_x        (rsp_speed_x),
      .rsp_speed_y        (rsp_speed_y),
      .rsp_turn_rate      (rsp_turn_rate),
      .rsp_done_res       (rsp_done_res)
   );

endmodule

@@ src/cbps_checker.sv @@
// port-level checks of the path sampler and their binding
module cbps_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_func,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_target_x,
   input logic               rsp_done_res
);

   // no response straight out of reset
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a sample request occupies the block
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_func) |=> req_stall)
      else $error("block free right after a sample request");

   // a point write keeps the block free
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_func) |=> !req_stall)
      else $error("block stalled after a point write");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_target_x) && $stable(rsp_done_res)))
      else $error("stalled response changed");

endmodule

bind cubic_bspline_path_sampler cbps_checker u_cbps_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_func     (req_func),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_target_x (rsp_target_x),
   .rsp_done_res (rsp_done_res)
);
